### design/tle_pkg.sv
// ----------------------------------------------------------------------------
// Terminal line editor package
// Byte codes, channel codes, register indexes and echo sequences shared by
// the channel interfaces, the line editor and its checker.
// ----------------------------------------------------------------------------
package tle_pkg;

  typedef logic [7:0] byte_t;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int PLEN_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROMPT_TEXT   = 8'd0,
    REG_PROMPT_LENGTH = 8'd1
  } cfg_reg_e;

  localparam logic CH_ECHO = 1'b0;
  localparam logic CH_CMD  = 1'b1;

  localparam byte_t KEY_CTRL_C   = 8'h03;
  localparam byte_t KEY_BS       = 8'h08;
  localparam byte_t KEY_LF       = 8'h0A;
  localparam byte_t KEY_CR       = 8'h0D;
  localparam byte_t KEY_DEL      = 8'h7F;
  localparam byte_t PRINT_LO     = 8'h20;
  localparam byte_t PRINT_HI     = 8'h7E;

  localparam logic [PLEN_W-1:0] PROMPT_MAX = 4'd8;
  localparam logic [63:0]       PROMPT_TEXT_RST = 64'h0000_0000_0000_203E;
  localparam logic [PLEN_W-1:0] PROMPT_LEN_RST  = 4'd2;

  localparam logic [23:0] ERASE_SEQ = {8'h08, 8'h20, 8'h08};
  localparam logic [23:0] INTR_SEQ  = {8'h5E, 8'h43, 8'h0A};

  localparam int LONG_LEN = 29;
  localparam logic [LONG_LEN*8-1:0] LONG_MSG = "error: command line too long\n";

  function automatic byte_t seq3_byte(logic [23:0] seq, logic [1:0] i);
    byte_t b;
    case (i)
      2'd0:    b = seq[23:16];
      2'd1:    b = seq[15:8];
      default: b = seq[7:0];
    endcase
    return b;
  endfunction

  function automatic byte_t long_msg_byte(logic [4:0] i);
    int pos;
    pos = LONG_LEN - 1 - int'(i);
    if (pos < 0) begin
      pos = 0;
    end
    return LONG_MSG[pos*8 +: 8];
  endfunction

endpackage

### design/tle_if.sv
// ----------------------------------------------------------------------------
// Terminal line editor channels
// Valid/ready channels for received bytes, result items and register writes.
// ----------------------------------------------------------------------------
interface tle_in_if;
  import tle_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tle_out_if;
  import tle_pkg::*;
  logic  valid;
  logic  ready;
  logic  channel;
  byte_t out_byte;
  logic  last;

  modport source (output valid, output channel, output out_byte, output last, input ready);
  modport sink   (input valid, input channel, input out_byte, input last, output ready);
endinterface

interface tle_cfg_if;
  import tle_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// Terminal line editor
// Canonical-mode line editing with echo, erase, interrupt and line dispatch.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                     Handshake
//  in_if     sink       in_byte                     valid/ready
//  out_if    source     channel, out_byte, last     valid/ready
//  cfg_if    sink       index, data                 valid/ready, always ready
//
//  A byte is accepted whenever the sequencer is idle; its results then leave
//  one per cycle through the output register while the output is not stalled,
//  up to 40 of them at a line end with the default LINE_BYTES.
//  Line bytes are read from the line memory into a data register ahead of their output.
//  Reset is asynchronous and leaves an empty line with the prompt "> ".
//  A stalled output holds the sequence in place without losing any item.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
  parameter int LINE_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tle_in_if.sink    in_if,
  tle_out_if.source out_if,
  tle_cfg_if.sink   cfg_if
);
  import tle_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int IW = (AW > 5) ? AW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_ERASE,
    S_INTR,
    S_NL,
    S_LONG,
    S_LINE,
    S_PROMPT
  } state_e;

  state_e              state_q, state_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       fill_q, fill_d;
  logic [AW-1:0]       line_len_q, line_len_d;
  logic                ovf_q, ovf_d;
  logic                long_q, long_d;
  logic                swallow_q, swallow_d;
  byte_t               echo_q, echo_d;
  logic [63:0]         prompt_text_q, prompt_text_d;
  logic [PLEN_W-1:0]   prompt_len_q, prompt_len_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ch_q, out_ch_d;
  byte_t               out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  byte_t               line_mem [LINE_BYTES];
  byte_t               rd_data_q;
  logic                wr_en;

  logic                adv;
  logic                emit_v;
  logic                emit_ch;
  byte_t               emit_byte;
  logic                emit_last;
  logic                fin;
  logic [PLEN_W-1:0]   plen_eff;
  logic                no_prompt;
  state_e              tail_state;
  byte_t               b;

  assign in_if.ready     = (state_q == S_IDLE);
  assign cfg_if.ready    = 1'b1;
  assign out_if.valid    = out_valid_q;
  assign out_if.channel  = out_ch_q;
  assign out_if.out_byte = out_byte_q;
  assign out_if.last     = out_last_q;

  assign adv        = !out_valid_q || out_if.ready;
  assign plen_eff   = (prompt_len_q > PROMPT_MAX) ? PROMPT_MAX : prompt_len_q;
  assign no_prompt  = (plen_eff == '0);
  assign tail_state = no_prompt ? S_IDLE : S_PROMPT;
  assign b          = in_if.in_byte;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    fill_d        = fill_q;
    line_len_d    = line_len_q;
    ovf_d         = ovf_q;
    long_d        = long_q;
    swallow_d     = swallow_q;
    echo_d        = echo_q;
    prompt_text_d = prompt_text_q;
    prompt_len_d  = prompt_len_q;
    wr_en         = 1'b0;
    emit_v        = 1'b0;
    emit_ch       = CH_ECHO;
    emit_byte     = echo_q;
    emit_last     = 1'b0;
    fin           = 1'b0;

    if (cfg_if.valid) begin
      if (cfg_if.index == REG_PROMPT_TEXT) begin
        prompt_text_d = cfg_if.data;
      end else if (cfg_if.index == REG_PROMPT_LENGTH) begin
        prompt_len_d = cfg_if.data[PLEN_W-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          swallow_d = 1'b0;
          idx_d     = '0;
          if (swallow_q && b == KEY_LF) begin
            state_d = S_IDLE;
          end else if (b == KEY_CR || b == KEY_LF) begin
            line_len_d = fill_q;
            long_d     = ovf_q;
            fill_d     = '0;
            ovf_d      = 1'b0;
            swallow_d  = (b == KEY_CR);
            state_d    = S_NL;
          end else if (b == KEY_CTRL_C) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_INTR;
          end else if (ovf_q) begin
            state_d = S_IDLE;
          end else if (b == KEY_BS || b == KEY_DEL) begin
            if (fill_q != '0) begin
              fill_d  = fill_q - AW'(1);
              state_d = S_ERASE;
            end
          end else if (b < PRINT_LO || b > PRINT_HI) begin
            state_d = S_IDLE;
          end else if (fill_q == AW'(LINE_BYTES - 1)) begin
            ovf_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            fill_d  = fill_q + AW'(1);
            echo_d  = b;
            state_d = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        emit_v    = 1'b1;
        emit_byte = echo_q;
        emit_last = 1'b1;
        if (adv) begin
          state_d = S_IDLE;
        end
      end
      S_ERASE: begin
        fin       = (idx_q == IW'(2));
        emit_v    = 1'b1;
        emit_byte = seq3_byte(ERASE_SEQ, idx_q[1:0]);
        emit_last = fin;
        if (adv) begin
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_INTR: begin
        fin       = (idx_q == IW'(2));
        emit_v    = 1'b1;
        emit_byte = seq3_byte(INTR_SEQ, idx_q[1:0]);
        emit_last = fin && no_prompt;
        if (adv) begin
          if (fin) begin
            idx_d   = '0;
            state_d = tail_state;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_NL: begin
        emit_v    = 1'b1;
        emit_byte = KEY_LF;
        emit_last = !long_q && (line_len_q == '0) && no_prompt;
        if (adv) begin
          idx_d = '0;
          if (long_q) begin
            state_d = S_LONG;
          end else if (line_len_q != '0) begin
            state_d = S_LINE;
          end else begin
            state_d = tail_state;
          end
        end
      end
      S_LONG: begin
        fin       = (idx_q == IW'(LONG_LEN - 1));
        emit_v    = 1'b1;
        emit_byte = long_msg_byte(idx_q[4:0]);
        emit_last = fin && no_prompt;
        if (adv) begin
          if (fin) begin
            idx_d   = '0;
            state_d = tail_state;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_LINE: begin
        fin       = ((idx_q + IW'(1)) == IW'(line_len_q));
        emit_v    = 1'b1;
        emit_ch   = CH_CMD;
        emit_byte = rd_data_q;
        emit_last = fin && no_prompt;
        if (adv) begin
          if (fin) begin
            idx_d   = '0;
            state_d = tail_state;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_PROMPT: begin
        fin       = ((idx_q + IW'(1)) == IW'(plen_eff));
        emit_v    = 1'b1;
        emit_byte = prompt_text_q[{idx_q[2:0], 3'b000} +: 8];
        emit_last = fin;
        if (adv) begin
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    out_ch_d    = out_ch_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = emit_v;
      out_ch_d    = emit_ch;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      fill_q        <= '0;
      line_len_q    <= '0;
      ovf_q         <= 1'b0;
      long_q        <= 1'b0;
      swallow_q     <= 1'b0;
      prompt_text_q <= PROMPT_TEXT_RST;
      prompt_len_q  <= PROMPT_LEN_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      fill_q        <= fill_d;
      line_len_q    <= line_len_d;
      ovf_q         <= ovf_d;
      long_q        <= long_d;
      swallow_q     <= swallow_d;
      prompt_text_q <= prompt_text_d;
      prompt_len_q  <= prompt_len_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    echo_q     <= echo_d;
    out_ch_q   <= out_ch_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[fill_q] <= b;
    end
    if (state_d == S_LINE) begin
      rd_data_q <= line_mem[idx_d[AW-1:0]];
    end
  end

endmodule

### design/tle_checker.sv
// ----------------------------------------------------------------------------
// Terminal line editor checker
// Port-level assertions on the line editor, attached by a bind statement.
// ----------------------------------------------------------------------------
module tle_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic         out_channel_i,
  input tle_pkg::byte_t out_byte_i,
  input logic         out_last_i
);
  import tle_pkg::*;

  logic prev_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
    end else if (out_valid_i && out_ready_i) begin
      prev_last_q <= out_last_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(out_channel_i) && $stable(out_last_i))
    else $error("result item changed while stalled");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while a result sequence is unfinished");

  a_cmd_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_channel_i == CH_CMD |->
      out_byte_i >= PRINT_LO && out_byte_i <= PRINT_HI)
    else $error("command byte is not printable");

  a_cmd_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_channel_i == CH_CMD |-> !prev_last_q)
    else $error("command byte opens a result sequence");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_channel_i (out_if.channel),
  .out_byte_i    (out_if.out_byte),
  .out_last_i    (out_if.last)
);
